// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ready-queue RTL.
// Self-contained; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i outside reset.
`define PRQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define PRQS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/prqs_pkg.sv -----
// Types and codes for the fixed-priority ready-queue scheduler.
// No dependencies; used by the top level.
package prqs_pkg;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_TAKE     = 2'd1,
    OP_SET_PRIO = 2'd2,
    OP_PICK     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAME  = 2'd1,
    ST_BUSY  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    op_e        operation;
    logic [2:0] task_number;
    logic [3:0] new_priority;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] chosen_task;
    logic [3:0] old_priority;
  } out_t;

endpackage

// ----- hdl/priority_ready_queue_scheduler.sv -----
// Fixed-priority FIFO ready queue: top level with input, queue state and result registers.
// Depends on prqs_pkg, prqs_pick and assert_macros.svh.
//
// One operation (put, take, set priority, pick) is accepted per clock unless the input side
// stalls. It is held in the input register, then the queue update and the level priority
// encode run in one pass into the result register, from which the single result is presented.
// A stalled result holds the input register, and the input side stalls only while both
// registers are full and the result is stalled.
`include "assert_macros.svh"

module priority_ready_queue_scheduler #(
  parameter int TASKS  = 8,
  parameter int LEVELS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  prqs_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output prqs_pkg::out_t out_o
);
  import prqs_pkg::*;

  localparam int TW = $clog2(TASKS);
  localparam int LW = $clog2(LEVELS);

  logic          stage_valid_q;
  in_t           stage_q;
  logic          out_valid_q;
  out_t          out_q;
  logic          out_load;
  logic          fire;
  logic          accept;

  logic [TW-1:0] head_q [LEVELS];
  logic [TW-1:0] head_d [LEVELS];
  logic [TW-1:0] tail_q [LEVELS];
  logic [TW-1:0] tail_d [LEVELS];
  logic [TW-1:0] link_q [TASKS];
  logic [TW-1:0] link_d [TASKS];
  logic [LW-1:0] level_q [TASKS];
  logic [LW-1:0] level_d [TASKS];
  logic [LEVELS-1:0] head_v_q, head_v_d;
  logic [LEVELS-1:0] tail_v_q, tail_v_d;
  logic [TASKS-1:0]  link_v_q, link_v_d;
  logic [TASKS-1:0]  ready_q, ready_d;

  logic [2:0]    t_mod;
  logic [TW-1:0] t_idx;
  logic [LW-1:0] np_lvl;
  logic [LW-1:0] lv;
  logic          pick_found;
  logic [TW-1:0] pick_task;
  out_t          res;
  logic          put_ok;
  logic          take_ok;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign fire        = stage_valid_q && out_load;
  assign in_stall_o  = stage_valid_q && !out_load;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // task number folded into range
  always_comb begin
    t_mod = stage_q.task_number;
    for (int k = 0; k < 4; k++) begin
      if (32'(t_mod) >= TASKS) begin
        t_mod = t_mod - 3'(TASKS);
      end
    end
  end

  assign t_idx  = TW'(t_mod);
  assign np_lvl = (32'(stage_q.new_priority) >= LEVELS) ? LW'(LEVELS - 1)
                                                        : LW'(stage_q.new_priority);
  assign lv     = level_q[t_idx];

  prqs_pick #(
    .TASKS  (TASKS),
    .LEVELS (LEVELS)
  ) u_pick (
    .head_valid_i (head_v_q),
    .head_i       (head_q),
    .found_o      (pick_found),
    .task_o       (pick_task)
  );

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    link_d   = link_q;
    level_d  = level_q;
    head_v_d = head_v_q;
    tail_v_d = tail_v_q;
    link_v_d = link_v_q;
    ready_d  = ready_q;
    res        = '0;
    res.status = ST_OK;
    if (fire) begin
      unique case (stage_q.operation)
        OP_PUT: begin
          if (ready_q[t_idx]) begin
            res.status = ST_SAME;
          end else begin
            if (tail_v_q[lv]) begin
              link_d[tail_q[lv]]   = t_idx;
              link_v_d[tail_q[lv]] = 1'b1;
            end else begin
              head_d[lv]   = t_idx;
              head_v_d[lv] = 1'b1;
            end
            tail_d[lv]      = t_idx;
            tail_v_d[lv]    = 1'b1;
            link_v_d[t_idx] = 1'b0;
            ready_d[t_idx]  = 1'b1;
          end
        end
        OP_TAKE: begin
          if (!ready_q[t_idx]) begin
            res.status = ST_SAME;
          end else begin
            if (link_v_q[t_idx]) begin
              head_d[lv]   = link_q[t_idx];
              head_v_d[lv] = 1'b1;
            end else begin
              head_v_d[lv] = 1'b0;
              tail_v_d[lv] = 1'b0;
            end
            ready_d[t_idx]  = 1'b0;
            link_v_d[t_idx] = 1'b0;
          end
        end
        OP_SET_PRIO: begin
          res.old_priority = 4'(level_q[t_idx]);
          if (ready_q[t_idx]) begin
            res.status = ST_BUSY;
          end else begin
            level_d[t_idx] = np_lvl;
          end
        end
        OP_PICK: begin
          res.status      = pick_found ? ST_OK : ST_EMPTY;
          res.chosen_task = pick_found ? 3'(pick_task) : 3'd0;
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      head_v_q      <= '0;
      tail_v_q      <= '0;
      link_v_q      <= '0;
      ready_q       <= '0;
      for (int i = 0; i < TASKS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        stage_valid_q <= 1'b1;
      end else if (fire) begin
        stage_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= stage_valid_q;
      end
      head_v_q <= head_v_d;
      tail_v_q <= tail_v_d;
      link_v_q <= link_v_d;
      ready_q  <= ready_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= in_i;
    end
    if (fire) begin
      out_q <= res;
    end
    head_q <= head_d;
    tail_q <= tail_d;
    link_q <= link_d;
  end

  assign put_ok  = fire && stage_q.operation == OP_PUT && res.status == ST_OK;
  assign take_ok = fire && stage_q.operation == OP_TAKE && res.status == ST_OK;

  `PRQS_ASSERT(a_put_marks_ready, put_ok |=> ready_q[$past(t_idx)], "put left task not ready")
  `PRQS_ASSERT(a_take_clears_ready, take_ok |=> !ready_q[$past(t_idx)], "take left task ready")
  `PRQS_ASSERT_ALWAYS(a_stall_has_item, in_stall_o |-> stage_valid_q, "stall without item")

endmodule

// ----- hdl/prqs_pick.sv -----
// Priority encoder over the per-level head registers: lowest valid level wins.
// Purely combinational; no package dependency.
module prqs_pick #(
  parameter int TASKS  = 8,
  parameter int LEVELS = 16
) (
  input  logic [LEVELS-1:0]        head_valid_i,
  input  logic [$clog2(TASKS)-1:0] head_i [LEVELS],
  output logic                     found_o,
  output logic [$clog2(TASKS)-1:0] task_o
);

  always_comb begin
    found_o = 1'b0;
    task_o  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (head_valid_i[i]) begin
        found_o = 1'b1;
        task_o  = head_i[i];
      end
    end
  end

endmodule

// ----- verif/tb_priority_ready_queue_scheduler.sv -----
// Self-checking testbench for the fixed-priority ready-queue scheduler.
// Depends on prqs_pkg and priority_ready_queue_scheduler; a scoreboard class predicts every
// result from a private copy of the queue state and checks results in order of acceptance.
module tb_priority_ready_queue_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import prqs_pkg::*;

  class ready_queue_sb;
    localparam int NUM_TASKS  = 8;
    localparam int NUM_LEVELS = 16;

    bit [2:0] head   [NUM_LEVELS];
    bit       head_v [NUM_LEVELS];
    bit [2:0] tail   [NUM_LEVELS];
    bit       tail_v [NUM_LEVELS];
    bit [2:0] link   [NUM_TASKS];
    bit       link_v [NUM_TASKS];
    bit       ready  [NUM_TASKS];
    bit [3:0] level  [NUM_TASKS];
    out_t     pending[$];
    int       errors;

    function new();
      errors = 0;
      foreach (head[i]) begin
        head[i] = '0; head_v[i] = 1'b0; tail[i] = '0; tail_v[i] = 1'b0;
      end
      foreach (link[i]) begin
        link[i] = '0; link_v[i] = 1'b0; ready[i] = 1'b0; level[i] = '0;
      end
    endfunction

    function int clamp_level(int v);
      return (v >= NUM_LEVELS) ? NUM_LEVELS - 1 : v;
    endfunction

    // True when task t sits at the head of its own level.
    function bit at_head(int t);
      int lv;
      lv = clamp_level(level[t]);
      return ready[t] && head_v[lv] && (head[lv] == t);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void note_input(in_t it);
      out_t r;
      int   t;
      int   lv;
      r = '0;
      t = it.task_number % NUM_TASKS;
      case (it.operation)
        OP_PUT: begin
          if (ready[t]) begin
            r.status = ST_SAME;
          end else begin
            lv = clamp_level(level[t]);
            if (tail_v[lv]) begin
              link[tail[lv] % NUM_TASKS]   = 3'(t);
              link_v[tail[lv] % NUM_TASKS] = 1'b1;
            end else begin
              head[lv]   = 3'(t);
              head_v[lv] = 1'b1;
            end
            tail[lv]   = 3'(t);
            tail_v[lv] = 1'b1;
            link[t]    = '0;
            link_v[t]  = 1'b0;
            ready[t]   = 1'b1;
            r.status   = ST_OK;
          end
        end
        OP_TAKE: begin
          if (!ready[t]) begin
            r.status = ST_SAME;
          end else begin
            lv = clamp_level(level[t]);
            if (link_v[t]) begin
              head[lv]   = link[t];
              head_v[lv] = 1'b1;
            end else begin
              head[lv]   = '0;
              head_v[lv] = 1'b0;
              tail[lv]   = '0;
              tail_v[lv] = 1'b0;
            end
            ready[t]  = 1'b0;
            link[t]   = '0;
            link_v[t] = 1'b0;
            r.status  = ST_OK;
          end
        end
        OP_SET_PRIO: begin
          r.old_priority = level[t];
          if (ready[t]) begin
            r.status = ST_BUSY;
          end else begin
            level[t] = 4'(clamp_level(it.new_priority));
            r.status = ST_OK;
          end
        end
        default: begin
          r.status = ST_EMPTY;
          for (int i = 0; i < NUM_LEVELS; i++) begin
            if (head_v[i]) begin
              r.chosen_task = head[i];
              r.status      = ST_OK;
              break;
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    task check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d task=%0d old=%0d",
                         got.status, got.chosen_task, got.old_priority));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.chosen_task !== exp.chosen_task)
        report($sformatf("chosen_task got %0d exp %0d", got.chosen_task, exp.chosen_task));
      if (got.old_priority !== exp.old_priority)
        report($sformatf("old_priority got %0d exp %0d", got.old_priority,
                         exp.old_priority));
    endtask
  endclass

  localparam int RANDOM_ITEMS = 1300;
  localparam int STUCK_LIMIT  = 2000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  ready_queue_sb sb = new();
  bit quiet = 1'b0;
  int stall_run = 0;
  int free_run = 0;
  int stuck_cycles = 0;

  priority_ready_queue_scheduler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_item(input in_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic send_op(input op_e op, input int t, input int p);
    in_t it;
    it.operation    = op;
    it.task_number  = 3'(t);
    it.new_priority = 4'(p);
    send_item(it);
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_t gen_item();
    in_t it;
    int  r;
    int  pool[$];
    it.operation    = OP_PICK;
    it.task_number  = 3'($urandom_range(0, 7));
    it.new_priority = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it.operation = op_e'($urandom_range(0, 3));
      return it;
    end
    if (r < 50) begin
      for (int t = 0; t < 8; t++) if (!sb.ready[t]) pool.push_back(t);
      if (pool.size() == 0) return it;
      it.task_number = 3'(pool[$urandom_range(0, pool.size() - 1)]);
      if (r < 32) begin
        it.operation = OP_PUT;
      end else begin
        it.operation = OP_SET_PRIO;
        if ($urandom_range(0, 9) < 7) it.new_priority = 4'($urandom_range(0, 3));
      end
    end else if (r < 75) begin
      for (int t = 0; t < 8; t++) if (sb.at_head(t)) pool.push_back(t);
      if (pool.size() == 0) return it;
      it.operation   = OP_TAKE;
      it.task_number = 3'(pool[$urandom_range(0, pool.size() - 1)]);
    end
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_o);
    if (stall_run > 0) begin
      stall_run--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (free_run > 0) begin
        free_run--;
      end else begin
        stall_run = idle_len();
        free_run  = $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_priority_ready_queue_scheduler: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, no-op take, priority extremes, busy refusal
    send_op(OP_PICK, 0, 0);
    send_op(OP_TAKE, 0, 0);
    send_op(OP_SET_PRIO, 7, 15);
    send_op(OP_SET_PRIO, 0, 0);
    send_op(OP_PUT, 7, 0);
    send_op(OP_PUT, 7, 0);
    send_op(OP_SET_PRIO, 7, 3);
    send_op(OP_PICK, 0, 0);
    // FIFO order within one level
    send_op(OP_PUT, 2, 0);
    send_op(OP_PUT, 3, 0);
    send_op(OP_PUT, 4, 0);
    send_op(OP_PICK, 0, 0);
    send_op(OP_TAKE, 2, 0);
    send_op(OP_PICK, 0, 0);
    // take of a task that is not at the head
    send_op(OP_TAKE, 4, 0);
    send_op(OP_PICK, 0, 0);
    send_op(OP_TAKE, 3, 0);
    send_op(OP_TAKE, 7, 0);
    send_op(OP_PICK, 0, 0);
    send_op(OP_SET_PRIO, 5, 15);
    send_op(OP_SET_PRIO, 5, 9);
    send_op(OP_PUT, 5, 0);
    send_op(OP_PICK, 0, 0);
    send_op(OP_TAKE, 5, 0);

    drain_queue();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 100) quiet = ~quiet;
      if (n == RANDOM_ITEMS / 2) drain_queue();
      send_item(gen_item());
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_priority_ready_queue_scheduler: clean");
    end else begin
      $display("tb_priority_ready_queue_scheduler: errors");
    end
    $finish;
  end
endmodule
